// ===== sv/s8ok_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// s8ok_pkg: shared types and constants for the srgb8 to oklch converter
// transaction structs, matrix coefficients, angle table, transfer curve table
// ----------------------------------------------------------------------------
package s8ok_pkg;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [15:0] lightness;
      logic [14:0] chroma;
      logic [15:0] hue;
   } rsp_type;

   // widest linear value, for the largest supported fraction width
   localparam int LIN_MAX_W = 25;
   typedef logic [255:0][LIN_MAX_W-1:0] lin_tab_type;

   localparam logic [15:0] THR_RESET = 16'd1;

   // matrix coefficients are integers over 1e10
   localparam longint unsigned COEF_DEN  = 64'd10000000000;
   localparam longint unsigned COEF_HALF = 64'd5000000000;
   // floor(2^65 / 1e10) for the reciprocal divide
   localparam longint unsigned RECIP_M   = 64'd3689348814;
   localparam int              RECIP_K   = 65;
   localparam int              MROW_LAT  = 6;
   localparam int              ANGLE_MAX = 24;

   localparam longint LMS_COEF [9] = '{
      64'sd4122214708, 64'sd5363325363, 64'sd514459929,
      64'sd2119034982, 64'sd6806995451, 64'sd1073969566,
      64'sd883024619,  64'sd2817188376, 64'sd6299787005};

   localparam longint LAB_COEF [9] = '{
      64'sd2104542553,  64'sd7936177850,   -64'sd40720468,
      64'sd19779984951, -64'sd24285922050, 64'sd4505937099,
      64'sd259040371,   64'sd7827717662,   -64'sd8086757660};

   localparam logic [31:0] TURN_TAB [ANGLE_MAX] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};

   localparam longint unsigned ONE31 = 64'd1 << 31;

   // q0.31 product, rounded half up
   function automatic longint unsigned mul31(input longint unsigned a,
                                             input longint unsigned b);
      mul31 = (a * b + (64'd1 << 30)) >> 31;
   endfunction

   function automatic longint unsigned pow5_31(input longint unsigned w);
      longint unsigned w2;
      w2 = mul31(w, w);
      pow5_31 = mul31(mul31(w2, w2), w);
   endfunction

   // srgb transfer curve for all 256 codes, evaluated at elaboration
   function automatic lin_tab_type build_lin_tab(input int frac);
      lin_tab_type     tab;
      longint unsigned c;
      longint unsigned num;
      longint unsigned x;
      longint unsigned z;
      longint unsigned w;
      longint unsigned cand;
      longint unsigned y;
      longint unsigned val;
      for (int ci = 0; ci < 256; ci++) begin
         c = longint'(ci);
         if (c * 100000 <= 1031475) begin
            val = (c * 100 * (64'd2 << frac) + 329460) / 658920;
         end else begin
            num = 1000 * c + 14025;
            x = ((num << 31) + 134512) / 269025;
            if (x > ONE31) x = ONE31;
            z = mul31(x, x);
            w = 0;
            for (int b = 31; b >= 0; b--) begin
               cand = w | (64'd1 << b);
               if (cand <= ONE31 && pow5_31(cand) <= z) w = cand;
            end
            y = mul31(z, w);
            val = (y + (64'd1 << (30 - frac))) >> (31 - frac);
         end
         tab[ci] = LIN_MAX_W'(val);
      end
      build_lin_tab = tab;
   endfunction

endpackage
`default_nettype wire

// ===== sv/s8ok_mrow.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// s8ok_mrow: one matrix row lane
// three products, sum, rounded divide by 1e10 through a reciprocal multiply
// ----------------------------------------------------------------------------
module s8ok_mrow
   import s8ok_pkg::*;
#(
   parameter int     FRAC_BITS = 16,
   parameter longint COEF_0    = 0,
   parameter longint COEF_1    = 0,
   parameter longint COEF_2    = 0
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [FRAC_BITS:0]          x0,
   input  logic [FRAC_BITS:0]          x1,
   input  logic [FRAC_BITS:0]          x2,
   output logic signed [FRAC_BITS+3:0] y
);

   localparam int XW  = FRAC_BITS + 1;
   localparam int CW  = 36;
   localparam int PW  = CW + XW + 1;
   localparam int NW  = PW + 2;
   localparam int MW  = FRAC_BITS + 36;
   localparam int SH  = MW - 31;
   localparam int QSH = RECIP_K - SH;
   localparam int QW  = FRAC_BITS + 3;
   localparam int OW  = FRAC_BITS + 4;

   localparam logic signed [CW-1:0] K0     = CW'(COEF_0);
   localparam logic signed [CW-1:0] K1     = CW'(COEF_1);
   localparam logic signed [CW-1:0] K2     = CW'(COEF_2);
   localparam logic signed [NW-1:0] HALF_N = NW'(COEF_HALF);
   localparam logic [33:0]          DEN_C  = 34'(COEF_DEN);

   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff;
   logic signed [NW-1:0] sum_ff;
   logic signed [NW-1:0] rnd_in;
   logic [MW-1:0]        mag3_ff, mag4_ff, mag5_ff;
   logic                 neg3_ff, neg4_ff, neg5_ff;
   logic [62:0]          prod_in;
   logic [QW-1:0]        qe4_ff, qe5_ff;
   logic [QW+33:0]       qd_in;
   logic [MW-1:0]        qd5_ff;
   logic [MW-1:0]        rem_in;
   logic [QW-1:0]        q_in;
   logic signed [OW-1:0] y_ff;

   // rounding is half away from zero, so work on the magnitude
   assign rnd_in  = sum_ff[NW-1] ? (HALF_N - sum_ff) : (sum_ff + HALF_N);
   assign prod_in = 63'(mag3_ff[MW-1:SH]) * 63'(RECIP_M);
   assign qd_in   = qe4_ff * DEN_C;
   // estimate is at most one short
   assign rem_in  = mag5_ff - qd5_ff;
   assign q_in    = (rem_in >= MW'(COEF_DEN)) ? qe5_ff + QW'(1) : qe5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff   <= K0 * $signed({1'b0, x0});
         p1_ff   <= K1 * $signed({1'b0, x1});
         p2_ff   <= K2 * $signed({1'b0, x2});
         sum_ff  <= NW'(p0_ff) + NW'(p1_ff) + NW'(p2_ff);
         mag3_ff <= MW'(rnd_in);
         neg3_ff <= sum_ff[NW-1];
         mag4_ff <= mag3_ff;
         neg4_ff <= neg3_ff;
         qe4_ff  <= QW'(prod_in >> QSH);
         mag5_ff <= mag4_ff;
         neg5_ff <= neg4_ff;
         qe5_ff  <= qe4_ff;
         qd5_ff  <= MW'(qd_in);
         y_ff    <= neg5_ff ? -$signed(OW'(q_in)) : $signed(OW'(q_in));
      end
   end

   assign y = y_ff;

endmodule
`default_nettype wire

// ===== sv/s8ok_cbrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// s8ok_cbrt: cube root lane
// clamps to 0..1.0, then one result bit per stage with running square and cube
// ----------------------------------------------------------------------------
module s8ok_cbrt
   import s8ok_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [FRAC_BITS+3:0] v,
   output logic [FRAC_BITS:0]          root
);

   localparam int F     = FRAC_BITS;
   localparam int OW    = F + 4;
   localparam int RW    = F + 1;
   localparam int R2W   = 2 * F + 2;
   localparam int CW    = 3 * F + 3;
   localparam int STEPS = F + 1;

   localparam logic signed [OW-1:0] ONE_V = {3'b000, 1'b1, {F{1'b0}}};
   localparam logic [RW-1:0]        ONE_R = {1'b1, {F{1'b0}}};

   logic [RW-1:0]  vc_in;
   logic [RW-1:0]  r_ff   [0:STEPS];
   logic [R2W-1:0] r2_ff  [0:STEPS];
   logic [CW-1:0]  r3_ff  [0:STEPS];
   logic [CW-1:0]  tgt_ff [0:STEPS];

   always_comb begin
      if (v < 0) begin
         vc_in = '0;
      end else if (v > ONE_V) begin
         vc_in = ONE_R;
      end else begin
         vc_in = v[F:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= '0;
         r2_ff[0]  <= '0;
         r3_ff[0]  <= '0;
         tgt_ff[0] <= CW'(vc_in) << (2 * F);
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam int B = F - k;
      logic [RW-1:0]  cand_in;
      logic [R2W-1:0] c2_in;
      logic [CW-1:0]  c3_in;
      logic           take_in;

      always_comb begin
         cand_in = r_ff[k] | (RW'(1) << B);
         c2_in   = r2_ff[k] + (R2W'(r_ff[k]) << (B + 1)) + (R2W'(1) << (2 * B));
         c3_in   = r3_ff[k] + (CW'(r2_ff[k]) << B) + (CW'(r2_ff[k]) << (B + 1))
                 + (CW'(r_ff[k]) << (2 * B)) + (CW'(r_ff[k]) << (2 * B + 1))
                 + (CW'(1) << (3 * B));
         // once the root reached 1.0 no candidate fits
         take_in = !r_ff[k][F] && (c3_in <= tgt_ff[k]);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k+1]   <= take_in ? cand_in : r_ff[k];
            r2_ff[k+1]  <= take_in ? c2_in : r2_ff[k];
            r3_ff[k+1]  <= take_in ? c3_in : r3_ff[k];
            tgt_ff[k+1] <= tgt_ff[k];
         end
      end
   end

   assign root = r_ff[STEPS];

endmodule
`default_nettype wire

// ===== sv/s8ok_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// s8ok_merge: merging stage
// chroma by bitwise square root, hue by cordic vectoring, output formatting
// ----------------------------------------------------------------------------
module s8ok_merge
   import s8ok_pkg::*;
#(
   parameter int FRAC_BITS   = 16,
   parameter int ANGLE_STEPS = 16
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [FRAC_BITS+3:0] l,
   input  logic signed [FRAC_BITS+3:0] a,
   input  logic signed [FRAC_BITS+3:0] b,
   input  logic [15:0]                 thr,
   output rsp_type                     rsp
);

   localparam int F   = FRAC_BITS;
   localparam int OW  = F + 4;
   localparam int RW  = F + 4;
   localparam int SW  = 2 * RW;
   localparam int XYW = F + 7;
   localparam int P   = (RW > ANGLE_STEPS) ? RW : ANGLE_STEPS;
   localparam int LQW = OW + 16;
   localparam int CQW = RW + 16;

   logic [SW-1:0]         sa_ff, sb_ff;
   logic signed [OW-1:0]  a0_ff, b0_ff, l0_ff;
   logic [SW-1:0]         n_ff   [0:P];
   logic [RW-1:0]         sr_ff  [0:P];
   logic [SW-1:0]         sr2_ff [0:P];
   logic signed [XYW-1:0] cx_ff  [0:P];
   logic signed [XYW-1:0] cy_ff  [0:P];
   logic [31:0]           ca_ff  [0:P];
   logic                  zero_ff[0:P];
   logic signed [OW-1:0]  l_ff   [0:P];
   logic [LQW-1:0]        lpos_in, lq_in;
   logic [CQW-1:0]        cq_in;
   logic [31:0]           hr_in;
   logic [15:0]           lgt_in;
   logic [14:0]           chr_in;
   rsp_type               rsp_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sa_ff      <= a * a;
         sb_ff      <= b * b;
         a0_ff      <= a;
         b0_ff      <= b;
         l0_ff      <= l;
         n_ff[0]    <= sa_ff + sb_ff;
         sr_ff[0]   <= '0;
         sr2_ff[0]  <= '0;
         zero_ff[0] <= (a0_ff == 0) && (b0_ff == 0);
         l_ff[0]    <= l0_ff;
         // left half plane is rotated by half a turn first
         if (a0_ff < 0) begin
            cx_ff[0] <= -XYW'(a0_ff);
            cy_ff[0] <= -XYW'(b0_ff);
            ca_ff[0] <= 32'h80000000;
         end else begin
            cx_ff[0] <= XYW'(a0_ff);
            cy_ff[0] <= XYW'(b0_ff);
            ca_ff[0] <= '0;
         end
      end
   end

   for (genvar k = 0; k < P; k++) begin : g_step
      logic [RW-1:0]         sr_in;
      logic [SW-1:0]         sr2_in;
      logic signed [XYW-1:0] cx_in, cy_in;
      logic [31:0]           ca_in;

      if (k < RW) begin : g_sqrt
         localparam int I = RW - 1 - k;
         logic [SW-1:0] t2;
         assign t2     = sr2_ff[k] + (SW'(sr_ff[k]) << (I + 1)) + (SW'(1) << (2 * I));
         assign sr_in  = (t2 <= n_ff[k]) ? (sr_ff[k] | (RW'(1) << I)) : sr_ff[k];
         assign sr2_in = (t2 <= n_ff[k]) ? t2 : sr2_ff[k];
      end else begin : g_sqrt_hold
         assign sr_in  = sr_ff[k];
         assign sr2_in = sr2_ff[k];
      end

      if (k < ANGLE_STEPS) begin : g_rot
         always_comb begin
            if (cy_ff[k] > 0) begin
               cx_in = cx_ff[k] + (cy_ff[k] >>> k);
               cy_in = cy_ff[k] - (cx_ff[k] >>> k);
               ca_in = ca_ff[k] + TURN_TAB[k];
            end else begin
               cx_in = cx_ff[k] - (cy_ff[k] >>> k);
               cy_in = cy_ff[k] + (cx_ff[k] >>> k);
               ca_in = ca_ff[k] - TURN_TAB[k];
            end
         end
      end else begin : g_rot_hold
         assign cx_in = cx_ff[k];
         assign cy_in = cy_ff[k];
         assign ca_in = ca_ff[k];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k+1]    <= n_ff[k];
            sr_ff[k+1]   <= sr_in;
            sr2_ff[k+1]  <= sr2_in;
            cx_ff[k+1]   <= cx_in;
            cy_ff[k+1]   <= cy_in;
            ca_ff[k+1]   <= ca_in;
            zero_ff[k+1] <= zero_ff[k];
            l_ff[k+1]    <= l_ff[k];
         end
      end
   end

   assign lpos_in = (l_ff[P] < 0) ? '0 : LQW'(l_ff[P][OW-2:0]);

   // rescale to q0.16
   if (F > 16) begin : g_down
      assign lq_in = (lpos_in + (LQW'(1) << (F - 17))) >> (F - 16);
      assign cq_in = (CQW'(sr_ff[P]) + (CQW'(1) << (F - 17))) >> (F - 16);
   end else begin : g_up
      assign lq_in = lpos_in << (16 - F);
      assign cq_in = CQW'(sr_ff[P]) << (16 - F);
   end

   assign lgt_in = (lq_in > LQW'(16'hFFFF)) ? 16'hFFFF : lq_in[15:0];
   assign chr_in = (cq_in > CQW'(15'h7FFF)) ? 15'h7FFF : cq_in[14:0];
   assign hr_in  = ca_ff[P] + 32'h00008000;

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff.lightness <= lgt_in;
         rsp_ff.chroma    <= chr_in;
         rsp_ff.hue       <= (zero_ff[P] || ({1'b0, chr_in} < thr)) ? 16'h0000
                                                                     : hr_in[31:16];
      end
   end

   assign rsp = rsp_ff;

endmodule
`default_nettype wire

// ===== sv/srgb8_to_oklch.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srgb8_to_oklch: 8-bit srgb pixel to oklch, fixed point
// table linearization, lms matrix, cube roots, lab matrix, chroma and hue
// ----------------------------------------------------------------------------
//
//  channel   ports               direction  transaction
//  req       req_valid/ready     in         one pixel: red, green, blue
//  rsp       rsp_valid/ready     out        one result: lightness, chroma, hue
//  csr       csr_wr_en/data      in         achromatic threshold write
//
// one pixel enters per clock while the pipeline is not stalled; the depth
// grows with FRAC_BITS and with ANGLE_ITERATIONS (capped by the angle table),
// set by the bit-per-stage cube root and square root/cordic pipelines
// synchronous reset clears the valid line and sets the threshold to 1
// when a result is not taken the whole pipeline holds and req_ready drops
//
module srgb8_to_oklch
   import s8ok_pkg::*;
#(
   parameter int FRAC_BITS        = 16,
   parameter int ANGLE_ITERATIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int LW    = FRAC_BITS + 1;
   localparam int OW    = FRAC_BITS + 4;
   // angle table has a fixed number of entries
   localparam int ITERS = (ANGLE_ITERATIONS < ANGLE_MAX) ? ANGLE_ITERATIONS : ANGLE_MAX;
   localparam int P     = (FRAC_BITS + 4 > ITERS) ? FRAC_BITS + 4 : ITERS;
   localparam int LAT   = 1 + MROW_LAT + (FRAC_BITS + 2) + MROW_LAT + 3 + P;

   localparam lin_tab_type LIN_TAB = build_lin_tab(FRAC_BITS);

   logic                 en;
   logic [LAT-1:0]       vld_ff;
   logic [LAT-1:0]       vld_in;
   logic [15:0]          thr_ff;
   logic [LW-1:0]        lin_ff [3];
   logic signed [OW-1:0] lms    [3];
   logic [LW-1:0]        root   [3];
   logic signed [OW-1:0] lab    [3];

   // pipeline advances unless the output register holds an untaken result
   assign en        = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LAT-1];
   assign vld_in    = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         thr_ff <= THR_RESET;
      end else begin
         if (en) vld_ff <= vld_in;
         if (csr_wr_en) thr_ff <= csr_wr_data;
      end
   end

   // transfer curve lookup, one table read per color channel
   always_ff @(posedge clock) begin
      if (en) begin
         lin_ff[0] <= LIN_TAB[req_data.red][LW-1:0];
         lin_ff[1] <= LIN_TAB[req_data.green][LW-1:0];
         lin_ff[2] <= LIN_TAB[req_data.blue][LW-1:0];
      end
   end

   // three lanes: lms row, cube root, lab row
   for (genvar i = 0; i < 3; i++) begin : g_lane
      s8ok_mrow #(
         .FRAC_BITS (FRAC_BITS),
         .COEF_0    (LMS_COEF[3*i]),
         .COEF_1    (LMS_COEF[3*i+1]),
         .COEF_2    (LMS_COEF[3*i+2])
      ) u_lms (
         .clock (clock),
         .en    (en),
         .x0    (lin_ff[0]),
         .x1    (lin_ff[1]),
         .x2    (lin_ff[2]),
         .y     (lms[i])
      );

      s8ok_cbrt #(
         .FRAC_BITS (FRAC_BITS)
      ) u_cbrt (
         .clock (clock),
         .en    (en),
         .v     (lms[i]),
         .root  (root[i])
      );

      s8ok_mrow #(
         .FRAC_BITS (FRAC_BITS),
         .COEF_0    (LAB_COEF[3*i]),
         .COEF_1    (LAB_COEF[3*i+1]),
         .COEF_2    (LAB_COEF[3*i+2])
      ) u_lab (
         .clock (clock),
         .en    (en),
         .x0    (root[0]),
         .x1    (root[1]),
         .x2    (root[2]),
         .y     (lab[i])
      );
   end

   // merge: chroma, hue, threshold, output register
   s8ok_merge #(
      .FRAC_BITS   (FRAC_BITS),
      .ANGLE_STEPS (ITERS)
   ) u_merge (
      .clock (clock),
      .en    (en),
      .l     (lab[0]),
      .a     (lab[1]),
      .b     (lab[2]),
      .thr   (thr_ff),
      .rsp   (rsp_data)
   );

   // a stalled pipeline keeps every stage's valid bit
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> $stable(vld_ff))
      else $error("valid line moved during stall");

   // no transaction enters while the output holds an untaken result
   a_no_accept_blocked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input accepted while output blocked");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule
`default_nettype wire

// ===== sim/oklch_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oklch_checker: predicts and checks srgb8_to_oklch results
// watches the pixel, result and threshold ports, computes the expected oklch
// value for each accepted pixel and compares it with the next result
// ----------------------------------------------------------------------------
module oklch_checker
   import s8ok_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          fail_count,
   output int          pending
);

   localparam int FB = 16;
   localparam int ITERS = 16;

   rsp_type         oklch_queue[$];
   logic [15:0]     threshold;
   longint unsigned linear_lut[256];

   function automatic longint unsigned prod31(input longint unsigned a,
                                              input longint unsigned b);
      return (a * b + (64'd1 << 30)) >> 31;
   endfunction

   function automatic longint unsigned curve_code(input int code);
      longint unsigned c, x, z, w, cand, w2, p5;
      c = longint'(code);
      if (c * 100000 <= 1031475)
         return (c * 100 * (64'd2 << FB) + 329460) / 658920;
      x = (((1000 * c + 14025) << 31) + 134512) / 269025;
      if (x > (64'd1 << 31)) x = 64'd1 << 31;
      z = prod31(x, x);
      w = 0;
      for (int b = 31; b >= 0; b--) begin
         cand = w | (64'd1 << b);
         w2 = prod31(cand, cand);
         p5 = prod31(prod31(w2, w2), cand);
         if (cand <= (64'd1 << 31) && p5 <= z) w = cand;
      end
      return (prod31(z, w) + (64'd1 << (30 - FB))) >> (31 - FB);
   endfunction

   // rounded division by 1e10, half away from zero
   function automatic longint round_coef(input logic signed [127:0] n);
      logic signed [127:0] q;
      if (n >= 0) q = (n + 128'sd5000000000) / 128'sd10000000000;
      else q = -((-n + 128'sd5000000000) / 128'sd10000000000);
      return longint'(q);
   endfunction

   function automatic longint unsigned floor_cbrt(input longint unsigned v);
      longint unsigned r, cand;
      logic [127:0] cube, lim;
      r = 0;
      lim = 128'(v) << (2 * FB);
      for (int b = FB; b >= 0; b--) begin
         cand = r | (64'd1 << b);
         cube = 128'(cand) * 128'(cand) * 128'(cand);
         if (cand <= (64'd1 << FB) && cube <= lim) r = cand;
      end
      return r;
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned n);
      longint unsigned r;
      r = 0;
      for (int b = 31; b >= 0; b--)
         if (128'(r | (64'd1 << b)) * 128'(r | (64'd1 << b)) <= 128'(n))
            r = r | (64'd1 << b);
      return r;
   endfunction

   // cordic vectoring, angle in 32-bit turns
   function automatic logic [15:0] cordic_hue(input longint a, input longint b);
      longint x, y, dx, dy;
      logic [31:0] ang;
      if (a == 0 && b == 0) return 16'd0;
      x = a; y = b; ang = 32'd0;
      if (x < 0) begin
         x = -x; y = -y; ang = 32'h80000000;
      end
      for (int i = 0; i < ITERS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; ang = ang + TURN_TAB[i];
         end else begin
            x -= dx; y += dy; ang = ang - TURN_TAB[i];
         end
      end
      return 16'((33'(ang) + 33'h8000) >> 16);
   endfunction

   function automatic rsp_type pixel_to_oklch(input req_type px);
      longint lin[3], root[3], lab[3], v;
      logic signed [127:0] acc;
      longint unsigned c;
      rsp_type r;
      lin[0] = longint'(linear_lut[px.red]);
      lin[1] = longint'(linear_lut[px.green]);
      lin[2] = longint'(linear_lut[px.blue]);
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) acc += 128'(LMS_COEF[3*i+j]) * 128'(lin[j]);
         v = round_coef(acc);
         if (v < 0) v = 0;
         if (v > (64'sd1 << FB)) v = 64'sd1 << FB;
         root[i] = longint'(floor_cbrt(longint'(v)));
      end
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) acc += 128'(LAB_COEF[3*i+j]) * 128'(root[j]);
         lab[i] = round_coef(acc);
      end
      r.lightness = lab[0] < 0 ? 16'd0 : (lab[0] > 65535 ? 16'hFFFF : 16'(lab[0]));
      c = floor_sqrt(longint'(lab[1] * lab[1] + lab[2] * lab[2]));
      r.chroma = c > 32767 ? 15'h7FFF : 15'(c);
      r.hue = cordic_hue(lab[1], lab[2]);
      if ({1'b0, r.chroma} < threshold) r.hue = 16'd0;
      return r;
   endfunction

   initial begin
      for (int i = 0; i < 256; i++) linear_lut[i] = curve_code(i);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         threshold <= THR_RESET;
         oklch_queue.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_wr_en) threshold <= csr_wr_data;
         if (req_valid && req_ready) oklch_queue.push_back(pixel_to_oklch(req_data));
         if (rsp_valid && rsp_ready) begin
            if (oklch_queue.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected result %h", rsp_data);
            end else begin
               want = oklch_queue.pop_front();
               if (want !== rsp_data) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: expected L %0d C %0d h %0d, got L %0d C %0d h %0d",
                        want.lightness, want.chroma, want.hue,
                        rsp_data.lightness, rsp_data.chroma, rsp_data.hue);
               end
            end
         end
         pending <= oklch_queue.size();
      end
   end

endmodule

// ===== sim/tb_srgb8_to_oklch.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_srgb8_to_oklch: stimulus and verdict for the srgb8 to oklch converter
// directed corner pixels, then random pixels under several threshold
// settings with random idling on both sides; the checker does the compare
// ----------------------------------------------------------------------------
module tb_srgb8_to_oklch;
   import s8ok_pkg::*;

   localparam int LATENCY = 54;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   int          fail_count;
   int          pending;
   bit          no_idle = 1'b0;

   always #5 clock = ~clock;

   srgb8_to_oklch dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data));

   oklch_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending(pending));

   // receiver stalls at random, 9 percent of the time, except in the no-idle stretch
   always @(posedge clock)
      rsp_ready <= no_idle || ($urandom_range(99) >= 9);

   // one pixel transaction; random gap before valid, then hold until taken
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
      while (!no_idle && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{red: r, green: g, blue: b};
      do @(posedge clock); while (!req_ready);
   endtask

   // wait until every expected result is in, then let the pipe drain
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // mostly random pixels, some near gray so that the threshold matters
   task automatic random_pixels(input int count);
      logic [7:0] base;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0) begin
            base = $urandom_range(255);
            send_pixel(base, base + 8'($urandom_range(4)) - 8'd2,
                       base + 8'($urandom_range(4)) - 8'd2);
         end else begin
            send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners: black, white, primaries, secondaries, linear-segment edge
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd10, 8'd10, 8'd10);
      send_pixel(8'd11, 8'd11, 8'd11);
      send_pixel(8'd10, 8'd11, 8'd0);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd170, 8'd85, 8'd170);
      send_pixel(8'd85, 8'd170, 8'd85);
      send_pixel(8'd0, 8'd1, 8'd2);
      drain();

      // threshold zero: hue kept except for the zero vector
      write_threshold(16'd0);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd200, 8'd200, 8'd200);
      random_pixels(100);
      drain();

      // back-to-back pixels and an always-ready receiver, no idling at all
      no_idle = 1'b1;
      write_threshold(16'd300);
      random_pixels(150);
      no_idle = 1'b0;
      drain();

      write_threshold(16'hFFFF);
      send_pixel(8'd255, 8'd0, 8'd255);
      random_pixels(100);
      drain();

      write_threshold(16'd1);
      random_pixels(150);
      drain();

      write_threshold(16'd2000);
      random_pixels(100);
      drain();

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // limit
   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

endmodule
